@@ hdl/etn_pkg.sv @@
// Shared types and constants of the EMA trend normalizer.
// No dependencies; every other file imports this package.
`default_nettype none

package etn_pkg;

    // Decay factor is unsigned Q0.16
    localparam int DECAY_BITS = 16;
    localparam int DECAY_IDX_W = $clog2(DECAY_BITS);
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = 16'd49152;
    localparam logic [DECAY_BITS-1:0] DECAY_HALF = 16'd32768;

    typedef logic [1:0] etn_op_t;

    localparam etn_op_t OP_PRICE  = 2'd0;
    localparam etn_op_t OP_STDEV  = 2'd1;
    localparam etn_op_t OP_HALT   = 2'd2;
    localparam etn_op_t OP_RESUME = 2'd3;

    localparam logic CAUSE_PRICE = 1'b0;
    localparam logic CAUSE_HALT  = 1'b1;

    // Command to the shared adder: optional left shift of operand a with a
    // bit shifted in, then add or subtract operand b
    typedef struct packed {
        logic shift;
        logic bin;
        logic sub;
    } etn_alu_cmd_t;

endpackage

`default_nettype wire

@@ hdl/etn_if.sv @@
// Channel interfaces of the EMA trend normalizer: events in, trends out,
// decay factor writes. Depends on etn_pkg.
`default_nettype none

interface etn_in_if import etn_pkg::*; #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    etn_op_t                       op;
    logic signed [VALUE_WIDTH-1:0] price;
    logic [VALUE_WIDTH-1:0]        stdev;

    modport source (output valid, output op, output price, output stdev, input ready);
    modport sink   (input valid, input op, input price, input stdev, output ready);
endinterface

interface etn_out_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] trend_value;
    logic                          cause;

    modport source (output valid, output trend_value, output cause, input ready);
    modport sink   (input valid, input trend_value, input cause, output ready);
endinterface

interface etn_cfg_if import etn_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [DECAY_BITS-1:0] decay_factor;

    modport source (output valid, output decay_factor, input ready);
    modport sink   (input valid, input decay_factor, output ready);
endinterface

`default_nettype wire

@@ hdl/etn_alu.sv @@
// Shared shift/add/subtract unit used by every arithmetic step.
// Depends on etn_pkg for the command struct.
`default_nettype none

module etn_alu import etn_pkg::*; #(
    parameter int WIDTH = 50
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  etn_alu_cmd_t     cmd,
    output logic [WIDTH-1:0] shifted,
    output logic [WIDTH-1:0] y
);

    assign shifted = cmd.shift ? {a[WIDTH-2:0], cmd.bin} : a;
    assign y       = cmd.sub ? (shifted - b) : (shifted + b);

endmodule

`default_nettype wire

@@ hdl/etn_core.sv @@
// Sequencer and state of the EMA trend normalizer: multiply, rounding and
// restoring division all run through one etn_alu. Depends on etn_pkg, etn_alu.
`default_nettype none

module etn_core import etn_pkg::*; #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_ready,
    input  etn_op_t                       evt_op,
    input  logic signed [VALUE_WIDTH-1:0] evt_price,
    input  logic [VALUE_WIDTH-1:0]        evt_stdev,
    input  logic [DECAY_BITS-1:0]         decay,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [VALUE_WIDTH-1:0] res_trend,
    output logic                          res_cause
);

    localparam int W     = VALUE_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int AW    = W + DECAY_BITS + 2;
    localparam int NW    = W + F;
    localparam int CNT_W = $clog2(W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_RND  = 4'd3;
    localparam logic [3:0] S_AVG  = 4'd4;
    localparam logic [3:0] S_ABS  = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SGN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     last_price_reg, last_price_next;
    logic [W-1:0]     avg_reg, avg_next;
    logic [W-1:0]     vol_reg, vol_next;
    logic             ready_flag_reg, ready_flag_next;
    logic             intr_flag_reg, intr_flag_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [AW-1:0]    aux_reg, aux_next;
    logic [W-2:0]     num_reg, num_next;
    logic             pos_reg, pos_next;
    logic [W-1:0]     res_trend_reg, res_trend_next;
    logic             res_cause_reg, res_cause_next;

    logic [AW-1:0]    alu_a, alu_b, alu_shifted, alu_y;
    etn_alu_cmd_t     alu_cmd;
    logic [AW-1:0]    price_ext, avg_ext, vol_ext, t_val;
    logic [NW-1:0]    num_full;

    etn_alu #(.WIDTH(AW)) u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .cmd     (alu_cmd),
        .shifted (alu_shifted),
        .y       (alu_y)
    );

    assign price_ext = {{(AW-W){last_price_reg[W-1]}}, last_price_reg};
    assign avg_ext   = {{(AW-W){avg_reg[W-1]}}, avg_reg};
    assign vol_ext   = {{(AW-W){1'b0}}, vol_reg};
    // Arithmetic shift of the rounded product by the decay scale
    assign t_val     = {{DECAY_BITS{acc_reg[AW-1]}}, acc_reg[AW-1:DECAY_BITS]};
    assign num_full  = {{F{1'b0}}, alu_y[W-1:0]} << F;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        last_price_next = last_price_reg;
        avg_next        = avg_reg;
        vol_next        = vol_reg;
        ready_flag_next = ready_flag_reg;
        intr_flag_next  = intr_flag_reg;
        acc_next        = acc_reg;
        aux_next        = aux_reg;
        num_next        = num_reg;
        pos_next        = pos_reg;
        res_trend_next  = res_trend_reg;
        res_cause_next  = res_cause_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_cmd         = '{shift: 1'b0, bin: 1'b0, sub: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    unique case (evt_op)
                        OP_PRICE:
                        begin
                            last_price_next = evt_price;
                            if (ready_flag_reg && !intr_flag_reg)
                            begin
                                state_next = S_DIFF;
                            end
                        end
                        OP_STDEV:
                        begin
                            if (!ready_flag_reg)
                            begin
                                ready_flag_next = 1'b1;
                                avg_next        = last_price_reg;
                            end
                            vol_next = evt_stdev;
                        end
                        OP_HALT:
                        begin
                            intr_flag_next = 1'b1;
                            res_trend_next = '0;
                            res_cause_next = CAUSE_HALT;
                            state_next     = S_OUT;
                        end
                        OP_RESUME:
                        begin
                            avg_next       = last_price_reg;
                            intr_flag_next = 1'b0;
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                // price - average, exact
                alu_a       = price_ext;
                alu_b       = avg_ext;
                alu_cmd.sub = 1'b1;
                aux_next    = alu_y;
                acc_next    = '0;
                cnt_next    = CNT_W'(DECAY_BITS - 1);
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                // accumulate -diff * decay, MSB of decay first
                alu_a         = acc_reg;
                alu_b         = decay[cnt_reg[DECAY_IDX_W-1:0]] ? aux_reg : '0;
                alu_cmd.shift = 1'b1;
                alu_cmd.sub   = 1'b1;
                acc_next      = alu_y;
                if (cnt_reg == '0)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_RND:
            begin
                alu_a      = acc_reg;
                alu_b      = {{(AW-DECAY_BITS){1'b0}}, DECAY_HALF};
                acc_next   = alu_y;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                // new average = price + t, and the trend difference is -t
                alu_a      = price_ext;
                alu_b      = t_val;
                avg_next   = alu_y[W-1:0];
                aux_next   = t_val;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                if (aux_reg == '0)
                begin
                    res_trend_next = '0;
                    res_cause_next = CAUSE_PRICE;
                    state_next     = S_OUT;
                end
                else
                begin
                    alu_b       = aux_reg;
                    alu_cmd.sub = aux_reg[AW-1];
                    pos_next    = aux_reg[AW-1];
                    acc_next    = {{(AW-F-1){1'b0}}, num_full[NW-1:W-1]};
                    num_next    = num_full[W-2:0];
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                // quotient would reach the sign bit: saturate
                alu_a       = acc_reg;
                alu_b       = vol_ext;
                alu_cmd.sub = 1'b1;
                if (!alu_y[AW-1])
                begin
                    res_trend_next = pos_reg ? VAL_MAX : VAL_MIN;
                    res_cause_next = CAUSE_PRICE;
                    state_next     = S_OUT;
                end
                else
                begin
                    aux_next   = '0;
                    cnt_next   = CNT_W'(W - 2);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                alu_a         = acc_reg;
                alu_b         = vol_ext;
                alu_cmd.shift = 1'b1;
                alu_cmd.bin   = num_reg[W-2];
                alu_cmd.sub   = 1'b1;
                acc_next      = alu_y[AW-1] ? alu_shifted : alu_y;
                aux_next      = {aux_reg[AW-2:0], ~alu_y[AW-1]};
                num_next      = {num_reg[W-3:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = S_SGN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SGN:
            begin
                alu_b          = {{(AW-W+1){1'b0}}, aux_reg[W-2:0]};
                alu_cmd.sub    = 1'b1;
                res_trend_next = pos_reg ? {1'b0, aux_reg[W-2:0]} : alu_y[W-1:0];
                res_cause_next = CAUSE_PRICE;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_price_reg <= '0;
            avg_reg        <= '0;
            vol_reg        <= W'(1) << F;
            ready_flag_reg <= 1'b0;
            intr_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_price_reg <= last_price_next;
            avg_reg        <= avg_next;
            vol_reg        <= vol_next;
            ready_flag_reg <= ready_flag_next;
            intr_flag_reg  <= intr_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        acc_reg       <= acc_next;
        aux_reg       <= aux_next;
        num_reg       <= num_next;
        pos_reg       <= pos_next;
        res_trend_reg <= res_trend_next;
        res_cause_reg <= res_cause_next;
    end

    assign evt_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_trend = res_trend_reg;
    assign res_cause = res_cause_reg;

endmodule

`default_nettype wire

@@ hdl/ema_trend_normalizer.sv @@
// Top level of the EMA trend normalizer: decay register, core, output register.
// Depends on etn_pkg, etn_if, etn_core.
//
//   channel  dir  payload                       handshake
//   cfg      in   decay_factor[15:0]            valid/ready, ready always high
//   events   in   op[1:0], price, stdev         valid/ready
//   trends   out  trend_value, cause            valid/ready
//
// A price sample that updates the average walks the difference, 16 multiply
// steps over the decay bits, rounding, the average, the magnitude, the
// saturation compare, VALUE_WIDTH - 1 restoring divide steps and the sign,
// all through the one shared adder. Its result then goes from the core
// through the output register to trends, and the core accepts the next item
// only once it is back in idle, not while a sample is in progress. A zero
// difference skips the divide, a saturated quotient leaves after the compare.
// Other events are handled in idle, an interruption also passes through the
// output state. Reset is asynchronous and active low and restores the state
// at once. A result waits in the output register; the core accepts the next
// item meanwhile and holds only if a second result finds that register full.
`default_nettype none

module ema_trend_normalizer import etn_pkg::*; #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    etn_cfg_if.sink    cfg,
    etn_in_if.sink     events,
    etn_out_if.source  trends
);

    logic [DECAY_BITS-1:0]         decay_reg;
    logic                          out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] out_trend_reg;
    logic                          out_cause_reg;

    logic                          res_valid;
    logic                          res_ready;
    logic signed [VALUE_WIDTH-1:0] res_trend;
    logic                          res_cause;

    // Writes must only come while idle; the block does not enforce this, ready stays high
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
        end
        else if (cfg.valid)
        begin
            decay_reg <= cfg.decay_factor;
        end
    end

    etn_core #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (events.valid),
        .evt_ready (events.ready),
        .evt_op    (events.op),
        .evt_price (events.price),
        .evt_stdev (events.stdev),
        .decay     (decay_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_trend (res_trend),
        .res_cause (res_cause)
    );

    // Load a new item when the register is empty or being drained
    assign res_ready = !out_valid_reg || trends.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (trends.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_trend_reg <= res_trend;
            out_cause_reg <= res_cause;
        end
    end

    assign trends.valid       = out_valid_reg;
    assign trends.trend_value = out_trend_reg;
    assign trends.cause       = out_cause_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench of the EMA trend normalizer: directed events, then random event streams
// under several decay settings, each result checked against an in-bench trend model.
// Depends on etn_pkg, etn_if and ema_trend_normalizer.
`timescale 1ns / 1ps

module tb;
    import etn_pkg::*;

    // Cycles for the core to finish a price sample, with margin
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic signed [31:0] trend;
        logic               cause;
    } trend_item_t;

    logic clk = 1'b0;
    logic rst_n;

    etn_cfg_if          cfg_bus ();
    etn_in_if  #(32)    event_bus ();
    etn_out_if #(32)    trend_bus ();

    ema_trend_normalizer #(
        .VALUE_WIDTH   (32),
        .FRACTION_BITS (16)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .events (event_bus),
        .trends (trend_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Model state of the normalizer, advanced once per accepted item
    logic signed [31:0] last_px;
    logic signed [31:0] avg_px;
    logic [31:0]        vol_q;
    logic               armed;
    logic               halted;
    logic [15:0]        decay_q;

    trend_item_t trends_due[$];
    int          error_count = 0;
    bit          steady = 1'b0;     // no idling on either side when set
    int          stall_left = 0;

    // Advance the model by one event; return 1 when the event emits a trend.
    function automatic bit predict_trend(input etn_op_t op, input logic signed [31:0] price,
                                         input logic [31:0] stdev, output trend_item_t res);
        longint          sum;
        longint          diff;
        longint unsigned mag;
        longint unsigned quo;
        res.trend = '0;
        res.cause = CAUSE_PRICE;
        case (op)
            OP_PRICE:
            begin
                last_px = price;
                if (!armed || halted)
                    return 1'b0;
                // Exact weighted sum, then round to nearest with ties upward
                sum = longint'(price) * longint'(32'd65536 - decay_q)
                    + longint'(avg_px) * longint'(decay_q);
                avg_px = (sum + 64'sd32768) >>> 16;
                diff = longint'(price) - longint'(avg_px);
                if (diff == 0)
                    res.trend = '0;
                else if (vol_q == '0)
                    res.trend = (diff > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                else
                begin
                    mag = (diff > 0) ? diff : -diff;
                    quo = (mag << 16) / {32'd0, vol_q};
                    if (diff > 0)
                        res.trend = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
                    else
                        res.trend = (quo > 64'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
                end
                return 1'b1;
            end
            OP_STDEV:
            begin
                if (!armed)
                begin
                    armed  = 1'b1;
                    avg_px = last_px;
                end
                vol_q = stdev;
                return 1'b0;
            end
            OP_HALT:
            begin
                halted    = 1'b1;
                res.cause = CAUSE_HALT;
                return 1'b1;
            end
            default:
            begin
                avg_px = last_px;
                halted = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    // Send one item, with an occasional idle burst ahead of it. Valid stays
    // high afterwards so that back-to-back items need no second assignment in
    // the same step; quiesce drops it.
    task automatic send_event(input etn_op_t op, input logic [31:0] price,
                              input logic [31:0] stdev);
        trend_item_t due;
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            event_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        event_bus.valid <= 1'b1;
        event_bus.op    <= op;
        event_bus.price <= price;
        event_bus.stdev <= stdev;
        do
            @(posedge clk);
        while (!event_bus.ready);
        if (predict_trend(op, $signed(price), stdev, due))
            trends_due.push_back(due);
    endtask

    // Drop valid, drain every pending trend, then let the core settle.
    task automatic quiesce();
        event_bus.valid <= 1'b0;
        while (trends_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_decay(input logic [15:0] decay);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.decay_factor <= decay;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        decay_q = decay;
    endtask

    // Before the first volatility update: prices only record the last price,
    // an interruption still emits its zero, a resume emits nothing.
    task automatic test_before_ready();
        send_event(OP_PRICE, 32'h0005_0000, '0);
        send_event(OP_PRICE, 32'hFFFC_8000, '0);
        send_event(OP_HALT, '0, '0);
        send_event(OP_RESUME, '0, '0);
        quiesce();
    endtask

    // First volatility update arms the block; then hit the extremes of price
    // and volatility, saturation both ways and the zero-volatility cases.
    task automatic test_volatility_extremes();
        send_event(OP_STDEV, 32'h7FFF_FFFF, 32'h0002_0000);
        send_event(OP_PRICE, 32'hFFFC_8000, '0);        // equals the average
        send_event(OP_PRICE, 32'h7FFF_FFFF, '0);
        send_event(OP_PRICE, 32'h8000_0000, '0);
        send_event(OP_STDEV, '0, 32'h0000_0001);         // one LSB
        send_event(OP_PRICE, 32'h0064_0000, '0);
        send_event(OP_PRICE, 32'hFF9C_0000, '0);
        send_event(OP_STDEV, '0, 32'hFFFF_FFFF);
        send_event(OP_PRICE, 32'h7FFF_FFFF, '0);
        send_event(OP_STDEV, '0, '0);
        send_event(OP_PRICE, 32'h000A_0000, '0);
        send_event(OP_PRICE, 32'hFFF6_0000, '0);
        // Reload the average so that the next sample matches it exactly
        send_event(OP_RESUME, '0, '0);
        send_event(OP_PRICE, 32'hFFF6_0000, '0);
        quiesce();
    endtask

    // While interrupted: prices are swallowed, volatility still moves, and a
    // resume restarts the average from the last price seen.
    task automatic test_interruption();
        send_event(OP_STDEV, '0, 32'h0001_8000);
        send_event(OP_HALT, '0, '0);
        send_event(OP_PRICE, 32'h0007_0000, '0);
        send_event(OP_STDEV, '0, 32'h0003_0000);
        send_event(OP_HALT, '0, '0);
        send_event(OP_RESUME, '0, '0);
        send_event(OP_PRICE, 32'h0007_4000, '0);
        quiesce();
    endtask

    // Random event stream under one decay setting. Most items are prices, half of
    // them near the running level so the average tracks; the rest are volatility
    // changes, interruptions and resumes, plus extremes and full-range noise.
    task automatic test_decay_phase(input logic [15:0] decay, input int count);
        etn_op_t     op;
        logic [31:0] px;
        logic [31:0] sd;
        int          pick;
        quiesce();
        write_decay(decay);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (halted && pick < 35)
                op = OP_RESUME;
            else if (pick < 75)
                op = OP_PRICE;
            else if (pick < 87)
                op = OP_STDEV;
            else if (pick < 93)
                op = OP_HALT;
            else
                op = OP_RESUME;
            px = $urandom;
            sd = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                px = last_px + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
            else if (pick == 5)
                px = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else if (pick < 8)
                px = int'($urandom_range(0, 1 << 18)) - (1 << 17);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                sd = $urandom >> $urandom_range(8, 31);
            else if (pick == 3)
                sd = '0;
            else if (pick == 4)
                sd = $urandom_range(1, 255);
            send_event(op, px, sd);
        end
    endtask

    // Receiver: hold ready low in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left      <= stall_left - 1;
            trend_bus.ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 7) == 0)
        begin
            stall_left      <= $urandom_range(0, 6);
            trend_bus.ready <= 1'b0;
        end
        else
            trend_bus.ready <= 1'b1;
    end

    // Compare every accepted trend with the oldest pending one.
    always @(posedge clk)
    begin
        if (rst_n && trend_bus.valid && trend_bus.ready)
        begin
            if (trends_due.size() == 0)
            begin
                $error("unexpected trend: trend_value %0d cause %0d",
                       trend_bus.trend_value, trend_bus.cause);
                error_count++;
            end
            else
            begin
                if (trend_bus.trend_value !== trends_due[0].trend)
                begin
                    $error("trend_value: expected %0d, actual %0d",
                           trends_due[0].trend, trend_bus.trend_value);
                    error_count++;
                end
                if (trend_bus.cause !== trends_due[0].cause)
                begin
                    $error("cause: expected %0d, actual %0d",
                           trends_due[0].cause, trend_bus.cause);
                    error_count++;
                end
                void'(trends_due.pop_front());
            end
        end
    end

    initial
    begin
        last_px = '0;
        avg_px  = '0;
        vol_q   = 32'h0001_0000;
        armed   = 1'b0;
        halted  = 1'b0;
        decay_q = DECAY_RESET;

        rst_n                <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.decay_factor <= '0;
        event_bus.valid      <= 1'b0;
        event_bus.op         <= OP_PRICE;
        event_bus.price      <= '0;
        event_bus.stdev      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_ready();
        test_volatility_extremes();
        test_interruption();
        test_decay_phase(16'd0, 65);
        test_decay_phase(16'hFFFF, 65);
        test_decay_phase(16'd1, 65);
        test_decay_phase(16'd32768, 65);
        test_decay_phase(16'($urandom_range(0, 65535)), 65);
        // Last stretch runs without idling on either side
        steady = 1'b1;
        test_decay_phase(DECAY_RESET, 65);
        quiesce();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Bound the run well beyond the slowest legal completion.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
